// ===== rtl/tli_pkg.sv =====
// shared types and codes of the table linear interpolator
package tli_pkg;

	localparam int FIELD_W = 32;
	localparam int OP_W    = 2;
	localparam int POS_W   = 7;
	localparam int ST_W    = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_NOBR  = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} tli_entry_t;

	typedef struct packed {
		logic               start;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] d;
	} tli_md_req_t;

endpackage

// ===== rtl/tli_table_mem.sv =====
// point table memory, one write and one registered read port
module tli_table_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  tli_pkg::tli_entry_t wr_data,
	input  logic [AW-1:0]       rd_addr,
	output tli_pkg::tli_entry_t rd_data
);
	import tli_pkg::*;

	tli_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/tli_muldiv.sv =====
// floor(a * b / d) with a < d: one multiply, then a 32-step shift-subtract divide
module tli_muldiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tli_pkg::tli_md_req_t         req,
	output logic                         done,
	output logic [tli_pkg::FIELD_W-1:0]  quot
);
	import tli_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_LOAD = 2'd1;
	localparam logic [1:0] P_RUN  = 2'd2;

	localparam int CNT_W = $clog2(FIELD_W);

	logic [1:0]           phase_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [2*FIELD_W-1:0] prod_q;
	logic [FIELD_W-1:0]   d_q;
	logic [FIELD_W-1:0]   rem_q;
	logic [FIELD_W-1:0]   lo_q;
	logic [FIELD_W-1:0]   quot_q;

	logic [FIELD_W:0]     trial;
	logic [FIELD_W:0]     diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, lo_q[FIELD_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						phase_q <= P_LOAD;
					end
				end
				P_LOAD: begin
					cnt_q   <= '0;
					phase_q <= P_RUN;
				end
				P_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FIELD_W - 1)) begin
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && req.start) begin
			prod_q <= (2*FIELD_W)'(req.a) * (2*FIELD_W)'(req.b);
			d_q    <= req.d;
		end
		if (phase_q == P_LOAD) begin
			rem_q  <= prod_q[2*FIELD_W-1:FIELD_W];
			lo_q   <= prod_q[FIELD_W-1:0];
			quot_q <= '0;
		end
		if (phase_q == P_RUN) begin
			rem_q  <= ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
			lo_q   <= {lo_q[FIELD_W-2:0], 1'b0};
			quot_q <= {quot_q[FIELD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/table_linear_interpolator_unit.sv =====
// top level of the table linear interpolator: sequencer, table and divider
//
// channel   direction  beat marked by          payload
// command   in         start && !busy          operation, point_x, point_y, query_x
// result    out        done, one cycle         value, insert_position, status
//
// clear, append and unused codes put their result on the ports in the first cycle after the beat.
// a query answers from S_FIRST for one point, from S_LAST at a clamped end, from S_SCAN for a match
// at entry i or when n points hold no bracket, and from S_DIV for a bracket in interval i:
// the interval scan reads one table entry per cycle, then the 32-step shift-subtract divider runs.
// arst_n clears the point count and the sequencer; table contents stay undefined.
// busy is high while a query runs; results cannot be stalled by the receiver.
module table_linear_interpolator_unit #(
	parameter int MAX_POINTS  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [tli_pkg::OP_W-1:0]            operation,
	input  logic signed [tli_pkg::FIELD_W-1:0]  point_x,
	input  logic signed [tli_pkg::FIELD_W-1:0]  point_y,
	input  logic signed [tli_pkg::FIELD_W-1:0]  query_x,
	output logic                                done,
	output logic signed [tli_pkg::FIELD_W-1:0]  value,
	output logic [tli_pkg::POS_W-1:0]           insert_position,
	output logic [tli_pkg::ST_W-1:0]            status
);
	import tli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
	localparam logic signed [64:0] SAT_MAX = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
	localparam logic signed [64:0] SAT_MIN = -SAT_MAX - 65'sd1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_LAST  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;

	logic [2:0]                 state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic                       done_q;
	logic signed [FIELD_W-1:0]  value_q;
	logic [POS_W-1:0]           insert_position_q;
	logic [ST_W-1:0]            status_q;

	logic signed [FIELD_W-1:0]  qx_q;
	tli_entry_t                 first_q;
	tli_entry_t                 prev_q;
	logic [AW-1:0]              idx_q;
	logic [CW-1:0]              pos_q;
	logic signed [FIELD_W-1:0]  ybase_q;
	logic [FIELD_W-1:0]         mdx_q, mdy_q, mdd_q;
	logic                       neg_q;
	logic                       dyz_q;

	logic                       accept;
	logic                       wr_en;
	logic [AW-1:0]              rd_addr;
	tli_entry_t                 rd_data;
	tli_entry_t                 wr_data;
	logic [CW-1:0]              cnt_m1;
	logic [CW-1:0]              idx2;

	logic                       asc, hi_end, lo_end;
	logic                       x_eq, bracket;
	logic signed [FIELD_W:0]    dx, dy, dd;
	logic [FIELD_W:0]           adx, ady, add;

	tli_md_req_t                md_req;
	logic                       md_done;
	logic [FIELD_W-1:0]         md_quot;
	logic signed [FIELD_W+2:0]  sq, sum;
	logic signed [64:0]         sum_w, sat;

	logic                       res_en;
	logic signed [FIELD_W-1:0]  res_val;
	logic [CW-1:0]              res_pos;
	logic [ST_W-1:0]            res_st;
	logic [CW+POS_W-1:0]        pos_ext;

	assign busy    = state_q != S_IDLE;
	assign accept  = start && !busy;
	assign cnt_m1  = count_q - CW'(1);
	assign idx2    = CW'(idx_q) + CW'(2);
	assign wr_data = '{x: point_x, y: point_y};

	tli_table_mem #(
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign md_req = '{start: state_q == S_MUL, a: mdx_q, b: mdy_q, d: mdd_q};

	tli_muldiv u_md (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.done  (md_done),
		.quot  (md_quot)
	);

	// interval tests and differences for the current pair
	always_comb begin
		x_eq    = qx_q == prev_q.x;
		bracket = (qx_q > prev_q.x && qx_q < rd_data.x) ||
			(qx_q < prev_q.x && qx_q > rd_data.x);
		dx  = {qx_q[FIELD_W-1], qx_q} - {prev_q.x[FIELD_W-1], prev_q.x};
		dy  = {rd_data.y[FIELD_W-1], rd_data.y} - {prev_q.y[FIELD_W-1], prev_q.y};
		dd  = {rd_data.x[FIELD_W-1], rd_data.x} - {prev_q.x[FIELD_W-1], prev_q.x};
		adx = dx[FIELD_W] ? -dx : dx;
		ady = dy[FIELD_W] ? -dy : dy;
		add = dd[FIELD_W] ? -dd : dd;
	end

	// end clamp tests, rd_data holds the last point in S_LAST
	always_comb begin
		asc    = rd_data.x > first_q.x;
		hi_end = asc ? (qx_q >= rd_data.x) : (qx_q <= rd_data.x);
		lo_end = asc ? (qx_q <= first_q.x) : (qx_q >= first_q.x);
	end

	// signed quotient, offset and saturation
	always_comb begin
		sq    = neg_q ? -$signed({3'b000, md_quot}) : $signed({3'b000, md_quot});
		if (dyz_q) begin
			sq = '0;
		end
		sum   = {{3{ybase_q[FIELD_W-1]}}, ybase_q} + sq;
		sum_w = {{(65-FIELD_W-3){sum[FIELD_W+2]}}, sum};
		if (sum_w > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (sum_w < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = sum_w;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		wr_en   = 1'b0;
		rd_addr = '0;
		res_en  = 1'b0;
		res_val = '0;
		res_pos = '0;
		res_st  = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_CLEAR: begin
							count_d = '0;
							res_en  = 1'b1;
						end
						OP_APPEND: begin
							res_en  = 1'b1;
							res_pos = count_q;
							if (count_q >= CNT_MAX) begin
								res_st = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						OP_QUERY: begin
							if (count_q == '0) begin
								res_en = 1'b1;
								res_st = ST_EMPTY;
							end else begin
								state_d = S_FIRST;
							end
						end
						default: begin
							res_en = 1'b1;
						end
					endcase
				end
			end
			S_FIRST: begin
				rd_addr = cnt_m1[AW-1:0];
				if (count_q == CW'(1)) begin
					res_en  = 1'b1;
					res_val = rd_data.y;
					res_pos = (qx_q > rd_data.x) ? CW'(1) : '0;
					state_d = S_IDLE;
				end else begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				rd_addr = AW'(1);
				if (hi_end) begin
					res_en  = 1'b1;
					res_val = rd_data.y;
					res_pos = count_q;
					state_d = S_IDLE;
				end else if (lo_end) begin
					res_en  = 1'b1;
					res_val = first_q.y;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_addr = idx2[AW-1:0];
				if (x_eq) begin
					res_en  = 1'b1;
					res_val = prev_q.y;
					res_pos = CW'(idx_q);
					state_d = S_IDLE;
				end else if (bracket) begin
					state_d = S_MUL;
				end else if (idx2 == count_q) begin
					res_en  = 1'b1;
					res_st  = ST_NOBR;
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (md_done) begin
					res_en  = 1'b1;
					res_val = sat[FIELD_W-1:0];
					res_pos = pos_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign pos_ext = {{POS_W{1'b0}}, res_pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			count_q           <= '0;
			done_q            <= 1'b0;
			value_q           <= '0;
			insert_position_q <= '0;
			status_q          <= ST_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= res_en;
			if (res_en) begin
				value_q           <= res_val;
				insert_position_q <= pos_ext[POS_W-1:0];
				status_q          <= res_st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= query_x;
		end
		if (state_q == S_FIRST) begin
			first_q <= rd_data;
			prev_q  <= rd_data;
		end
		if (state_q == S_LAST) begin
			idx_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (bracket && !x_eq) begin
				ybase_q <= prev_q.y;
				mdx_q   <= adx[FIELD_W-1:0];
				mdy_q   <= ady[FIELD_W-1:0];
				mdd_q   <= add[FIELD_W-1:0];
				neg_q   <= dx[FIELD_W] ^ dy[FIELD_W] ^ dd[FIELD_W];
				dyz_q   <= dy == '0;
				pos_q   <= CW'(idx_q) + CW'(1);
			end else begin
				prev_q <= rd_data;
				idx_q  <= idx_q + AW'(1);
			end
		end
	end

	assign done            = done_q;
	assign value           = value_q;
	assign insert_position = insert_position_q;
	assign status          = status_q;

endmodule

// ===== rtl/tli_checker.sv =====
// port-level checks of the table linear interpolator and their bind
module tli_checker #(
	parameter int MAX_POINTS = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic signed [tli_pkg::FIELD_W-1:0]  value,
	input logic [tli_pkg::POS_W-1:0]           insert_position,
	input logic [tli_pkg::ST_W-1:0]            status
);
	import tli_pkg::*;

	localparam logic [POS_W-1:0] FULL_POS = POS_W'(MAX_POINTS);

	// an accepted beat gives a result next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted beat neither answered nor busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

	a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query ended without a result");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> value == '0)
		else $error("nonzero value with error status");

	a_full_position: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> insert_position == FULL_POS)
		else $error("full status with wrong position");

endmodule

bind table_linear_interpolator_unit tli_checker #(.MAX_POINTS(MAX_POINTS)) u_chk (.*);

// ===== test/tli_tb_pkg.sv =====
`timescale 1ns / 100ps
// result predictor and checker for the table linear interpolator regression
package tli_tb_pkg;
	import tli_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [FIELD_W-1:0] value;
		logic [POS_W-1:0]          pos;
		logic [ST_W-1:0]           status;
	} interp_result_t;

	class table_interp_model;
		logic signed [FIELD_W-1:0] x_pts [TABLE_DEPTH];
		logic signed [FIELD_W-1:0] y_pts [TABLE_DEPTH];
		int unsigned               n_points;
		interp_result_t            pending[$];
		int                        errors;
		int                        printed;

		function new();
			n_points = 0;
			errors = 0;
			printed = 0;
		endfunction

		task report(string msg);
			errors++;
			if (printed < 40) begin
				$display("%0t mismatch: %s", $time, msg);
				printed++;
			end
		endtask

		function void note_command(logic [OP_W-1:0] op, logic signed [FIELD_W-1:0] px,
				logic signed [FIELD_W-1:0] py, logic signed [FIELD_W-1:0] qx);
			interp_result_t r;
			logic signed [FIELD_W-1:0] x_first, x_last, x0, x1, y0, y1;
			logic ascending, hit, neg;
			longint dx, dy, dd, sq, total;
			logic [63:0] mdx, mdy, mdd, quo;
			logic [127:0] prod;
			r.value = '0;
			r.pos = '0;
			r.status = ST_OK;
			case (op)
				OP_CLEAR: n_points = 0;
				OP_APPEND: begin
					if (n_points >= TABLE_DEPTH) begin
						r.pos = POS_W'(n_points);
						r.status = ST_FULL;
					end else begin
						x_pts[n_points] = px;
						y_pts[n_points] = py;
						r.pos = POS_W'(n_points);
						n_points++;
					end
				end
				OP_QUERY: begin
					if (n_points == 0) begin
						r.status = ST_EMPTY;
					end else if (n_points == 1) begin
						r.value = y_pts[0];
						r.pos = (qx > x_pts[0]) ? POS_W'(1) : POS_W'(0);
					end else begin
						x_first = x_pts[0];
						x_last = x_pts[n_points-1];
						ascending = x_last > x_first;
						if (ascending ? (qx >= x_last) : (qx <= x_last)) begin
							r.value = y_pts[n_points-1];
							r.pos = POS_W'(n_points);
						end else if (ascending ? (qx <= x_first) : (qx >= x_first)) begin
							r.value = y_pts[0];
						end else begin
							hit = 1'b0;
							for (int i = 0; i + 1 < n_points && !hit; i++) begin
								x0 = x_pts[i];
								x1 = x_pts[i+1];
								if (qx == x0) begin
									hit = 1'b1;
									r.value = y_pts[i];
									r.pos = POS_W'(i);
								end else if ((qx > x0 && qx < x1) || (qx < x0 && qx > x1)) begin
									hit = 1'b1;
									y0 = y_pts[i];
									y1 = y_pts[i+1];
									dx = longint'(qx) - longint'(x0);
									dy = longint'(y1) - longint'(y0);
									dd = longint'(x1) - longint'(x0);
									neg = ((dx < 0) ^ (dy < 0)) ^ (dd < 0);
									mdx = (dx < 0) ? 64'(-dx) : 64'(dx);
									mdy = (dy < 0) ? 64'(-dy) : 64'(dy);
									mdd = (dd < 0) ? 64'(-dd) : 64'(dd);
									// exact wide product, quotient truncated toward zero
									prod = 128'(mdx) * 128'(mdy);
									quo = 64'(prod / 128'(mdd));
									sq = neg ? -longint'(quo) : longint'(quo);
									if (dy == 0)
										sq = 0;
									total = longint'(y0) + sq;
									if (total > VAL_MAX)
										r.value = FIELD_W'(VAL_MAX);
									else if (total < VAL_MIN)
										r.value = FIELD_W'(VAL_MIN);
									else
										r.value = FIELD_W'(total);
									r.pos = POS_W'(i + 1);
								end
							end
							if (!hit)
								r.status = ST_NOBR;
						end
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task check_result(logic signed [FIELD_W-1:0] value, logic [POS_W-1:0] pos,
				logic [ST_W-1:0] status);
			interp_result_t e;
			if (pending.size() == 0) begin
				report($sformatf("result beat with nothing expected: value %h pos %0d status %0d",
					value, pos, status));
				return;
			end
			e = pending.pop_front();
			if (value !== e.value)
				report($sformatf("value %h, expected %h", value, e.value));
			if (pos !== e.pos)
				report($sformatf("insert_position %0d, expected %0d", pos, e.pos));
			if (status !== e.status)
				report($sformatf("status %0d, expected %0d", status, e.status));
		endtask
	endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// testbench top: drives commands into the interpolator and checks every result beat
module tb;
	import tli_pkg::*;
	import tli_tb_pkg::*;

	localparam int TOTAL_ITEMS = 1450;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] operation = OP_CLEAR;
	logic signed [FIELD_W-1:0] point_x = '0;
	logic signed [FIELD_W-1:0] point_y = '0;
	logic signed [FIELD_W-1:0] query_x = '0;
	logic busy;
	logic done;
	logic signed [FIELD_W-1:0] value;
	logic [POS_W-1:0] insert_position;
	logic [ST_W-1:0] status;

	table_interp_model model = new();
	int idle_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	table_linear_interpolator_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.point_x         (point_x),
		.point_y         (point_y),
		.query_x         (query_x),
		.done            (done),
		.value           (value),
		.insert_position (insert_position),
		.status          (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			model.check_result(value, insert_position, status);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] px,
			input logic [FIELD_W-1:0] py, input logic [FIELD_W-1:0] qx);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		@(posedge clk);
		while (busy) @(posedge clk);
		model.note_command(op, px, py, qx);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (model.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int k, nq, pick, n;
		longint lo, hi, pos, maxstep;
		logic [63:0] r64;
		logic signed [FIELD_W-1:0] qx, px;
		logic descending, narrow, scattered;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused code, single point
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0);
		send_item(OP_UNUSED, $urandom, $urandom, $urandom);
		send_item(OP_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h0);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0001_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h7fff_ffff);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h8000_0000);
		// ascending table
		send_item(OP_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h0);
		send_item(OP_APPEND, 32'h7fff_ffff, 32'h0000_0000, 32'h0);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0002_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0003_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h7fff_ffff);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h8000_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h1000_0000);
		// descending table
		send_item(OP_CLEAR, 32'h0, 32'h0, 32'h0);
		send_item(OP_APPEND, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
		send_item(OP_APPEND, 32'h0000_0000, 32'h1234_5678, 32'h0);
		send_item(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h4000_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0000_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h8000_0000);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h7fff_ffff);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'hc000_0000);
		// flat table
		send_item(OP_CLEAR, 32'h0, 32'h0, 32'h0);
		send_item(OP_APPEND, 32'h0001_0000, 32'h0000_0001, 32'h0);
		send_item(OP_APPEND, 32'h0001_0000, 32'h0000_0002, 32'h0);
		send_item(OP_QUERY, 32'h0, 32'h0, 32'h0001_0000);
		wait_for_results();

		while (items_sent < TOTAL_ITEMS) begin
			case ((items_sent / 150) % 4)
				1: idle_pct = 54;
				3: idle_pct = 27;
				default: idle_pct = 0;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			end else begin
				// mostly fresh tables; sometimes append on top of the old one
				if ($urandom_range(0, 5) != 0)
					send_item(OP_CLEAR, $urandom, $urandom, $urandom);
				pick = $urandom_range(0, 99);
				if (pick < 5)
					k = $urandom_range(60, 68);
				else if (pick < 12)
					k = 0;
				else
					k = $urandom_range(1, 10);
				descending = $urandom_range(0, 1);
				narrow = ($urandom_range(0, 2) == 0);
				scattered = ($urandom_range(0, 5) == 0);
				maxstep = narrow ? 64'sd8 : 64'sd4294967295 / (k + 1);
				if (narrow)
					pos = VAL_MIN + longint'($urandom_range(0, 32'hffff_f000));
				else
					pos = VAL_MIN + longint'($urandom) % maxstep;
				for (int j = 0; j < k; j++) begin
					if (scattered)
						px = $urandom;
					else
						px = descending ? ~FIELD_W'(pos) : FIELD_W'(pos);
					send_item(OP_APPEND, px, $urandom, $urandom);
					if (narrow)
						pos += longint'($urandom_range(0, 8));
					else
						pos += 1 + longint'($urandom) % maxstep;
				end
				nq = $urandom_range(1, 8);
				for (int j = 0; j < nq; j++) begin
					n = model.n_points;
					pick = $urandom_range(0, 9);
					if (n > 0 && pick < 3) begin
						qx = model.x_pts[$urandom_range(0, n - 1)];
					end else if (n > 0 && pick == 3) begin
						qx = model.x_pts[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
					end else if (n > 1 && pick < 7) begin
						lo = model.x_pts[0];
						hi = model.x_pts[n-1];
						if (lo > hi) begin
							pos = lo;
							lo = hi;
							hi = pos;
						end
						r64 = {$urandom, $urandom};
						qx = FIELD_W'(lo + longint'(r64 % 64'(hi - lo + 1)));
					end else if (pick == 7) begin
						qx = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
					end else begin
						qx = $urandom;
					end
					send_item(OP_QUERY, $urandom, $urandom, qx);
				end
				if ($urandom_range(0, 24) == 0)
					wait_for_results();
			end
		end

		wait_for_results();
		repeat (60) @(posedge clk);
		if (model.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
